/* rtl/core/taskbar_focus_hit_tester_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the taskbar focus hit tester
// Clocked assertion helpers used at the end of the modules that check
// their own logic. Every check is disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef TASKBAR_FOCUS_HIT_TESTER_UNIT_ASSERT_SVH
`define TASKBAR_FOCUS_HIT_TESTER_UNIT_ASSERT_SVH

// A property that must hold at every rising clock edge.
`define TFHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define TFHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/tfht_pkg.sv */
// ----------------------------------------------------------------------------
// Taskbar focus hit tester package
// Shared constants, item kind codes, register indexes and the control and
// status structs between the sequencer and the slot scan unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tfht_pkg;

  // Default number of window slots.
  localparam int MAX_WINDOWS_DEF = 16;

  // Button geometry on the bar.
  localparam int BTN_WIDTH  = 120;
  localparam int BTN_PITCH  = 124;
  localparam int BTN_SHRINK = 4;

  // Slots at or beyond this number have no bit in the open mask.
  localparam int MASK_SLOTS = 16;

  // Width of the column accumulator: bar_left plus sixteen pitches plus a width.
  localparam int XW = 14;

  // Item kinds.
  localparam logic [1:0] KIND_REGISTER  = 2'd0;
  localparam logic [1:0] KIND_SET_FOCUS = 2'd1;
  localparam logic [1:0] KIND_CLICK     = 2'd2;
  localparam logic [1:0] KIND_CYCLE     = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BAR_TOP    = 2'd0;
  localparam logic [1:0] CFG_BAR_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_BAR_LEFT   = 2'd2;

  // Register reset values.
  localparam logic [11:0] BAR_TOP_RST    = 12'd0;
  localparam logic [7:0]  BAR_HEIGHT_RST = 8'd32;
  localparam logic [11:0] BAR_LEFT_RST   = 12'd0;

  // Commands from the sequencer to the scan unit.
  typedef struct packed {
    logic load;
    logic step;
    logic click_mode;
  } scan_ctrl_t;

  // Scan unit status.
  typedef struct packed {
    logic done;
    logic found;
  } scan_status_t;

endpackage

/* rtl/core/taskbar_focus_hit_tester_unit.sv */
// Register and set focus items give their result in the cycle after the transfer.
// Click and cycle items scan one slot per cycle in the shared scan unit; the
// block is busy and takes no new item until the scan ends, and the result is
// registered from the last scan step.
// Results are strobed for one cycle; the receiver cannot stall them.
// Reset clears the window count, the focus and the bar registers to 0, 32, 0.
// ----------------------------------------------------------------------------
// Taskbar focus hit tester
// Tracks registered windows and the focused one, tests taskbar clicks
// against the button layout and cycles focus over the open windows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "taskbar_focus_hit_tester_unit_assert.svh"

module taskbar_focus_hit_tester_unit #(
  parameter int MaxWindows = tfht_pkg::MAX_WINDOWS_DEF,
  localparam int SW = $clog2(MaxWindows),
  localparam int CW = $clog2(MaxWindows + 1)
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Item command port
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  kind_i,
  input  logic [3:0]  window_index_i,
  input  logic [15:0] open_mask_i,
  input  logic [11:0] mouse_x_i,
  input  logic [11:0] mouse_y_i,
  // Result port
  output logic        result_valid_o,
  output logic        focus_valid_o,
  output logic [3:0]  focus_index_o,
  output logic        hit_o,
  output logic [3:0]  hit_index_o,
  output logic        register_ok_o,
  output logic [3:0]  register_slot_o,
  // Configuration write port
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;
  localparam int   XW      = tfht_pkg::XW;

  logic state_q, state_d;

  logic [11:0]   bar_top_q;
  logic [7:0]    bar_height_q;
  logic [11:0]   bar_left_q;

  logic [CW-1:0] count_q, count_d;
  logic          present_q, present_d;
  logic [SW-1:0] slot_q, slot_d;

  logic          res_valid_q, res_valid_d;
  logic          res_hit_q, res_hit_d;
  logic [3:0]    res_hit_idx_q, res_hit_idx_d;
  logic          res_reg_ok_q, res_reg_ok_d;
  logic [3:0]    res_reg_slot_q, res_reg_slot_d;
  logic          res_update;

  // Click mode of the running scan, kept beside the sequencer.
  logic          scan_click_q;

  logic                   accept;
  logic                   y_ok;
  logic [XW-1:0]          my_w;
  logic [XW-1:0]          top_w;
  logic [SW-1:0]          start_idx;
  logic [7:0]             count_ext;
  logic [7:0]             slot_ext;
  logic [7:0]             scan_ext;
  tfht_pkg::scan_ctrl_t   scan_ctrl;
  tfht_pkg::scan_status_t scan_status;
  logic [SW-1:0]          scan_idx;

  assign accept      = start_i && (state_q == ST_IDLE);
  assign busy_o      = (state_q == ST_SCAN);
  assign cfg_ready_o = 1'b1;

  // Row test of a click against the shrunken button band.
  assign my_w  = XW'(mouse_y_i);
  assign top_w = XW'(bar_top_q);
  assign y_ok  = (my_w >= top_w + XW'(tfht_pkg::BTN_SHRINK / 2)) &&
                 (my_w + XW'(tfht_pkg::BTN_SHRINK / 2) < top_w + XW'(bar_height_q));

  // The cycle starts after the focused slot, or after slot 0 without focus.
  assign start_idx = (present_q && (CW'(slot_q) < count_q)) ? slot_q : '0;

  assign count_ext = 8'(count_q);
  assign scan_ext  = 8'(scan_idx);

  tfht_scan_unit #(
    .MaxWindows (MaxWindows)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (scan_ctrl),
    .count_i     (count_q),
    .start_idx_i (start_idx),
    .mask_i      (open_mask_i),
    .mouse_x_i   (mouse_x_i),
    .bar_left_i  (bar_left_q),
    .y_ok_i      (y_ok),
    .status_o    (scan_status),
    .idx_o       (scan_idx)
  );

  // Sequencer and focus state update.
  always_comb begin
    state_d        = state_q;
    count_d        = count_q;
    present_d      = present_q;
    slot_d         = slot_q;
    res_valid_d    = 1'b0;
    res_update     = 1'b0;
    res_hit_d      = 1'b0;
    res_hit_idx_d  = 4'd0;
    res_reg_ok_d   = 1'b0;
    res_reg_slot_d = 4'd0;
    scan_ctrl      = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (kind_i)
            tfht_pkg::KIND_REGISTER: begin
              res_valid_d = 1'b1;
              res_update  = 1'b1;
              if (count_q < CW'(MaxWindows)) begin
                res_reg_ok_d   = 1'b1;
                res_reg_slot_d = count_ext[3:0];
                count_d        = count_q + CW'(1);
                if (!present_q) begin
                  present_d = 1'b1;
                  slot_d    = SW'(count_q);
                end
              end
            end
            tfht_pkg::KIND_SET_FOCUS: begin
              res_valid_d = 1'b1;
              res_update  = 1'b1;
              if (8'(window_index_i) < count_ext) begin
                present_d = 1'b1;
                slot_d    = SW'(window_index_i);
              end
            end
            default: begin
              scan_ctrl.load       = 1'b1;
              scan_ctrl.click_mode = (kind_i == tfht_pkg::KIND_CLICK);
              state_d              = ST_SCAN;
            end
          endcase
        end
      end
      ST_SCAN: begin
        scan_ctrl.step = 1'b1;
        if (scan_status.done) begin
          res_valid_d = 1'b1;
          res_update  = 1'b1;
          state_d     = ST_IDLE;
          if (scan_status.found) begin
            present_d = 1'b1;
            slot_d    = scan_idx;
            if (scan_click_q) begin
              res_hit_d     = 1'b1;
              res_hit_idx_d = scan_ext[3:0];
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Remember whether the running scan is a click.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_click_q <= 1'b0;
    end else if (scan_ctrl.load) begin
      scan_click_q <= scan_ctrl.click_mode;
    end
  end

  // Control and focus state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      present_q   <= 1'b0;
      slot_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      present_q   <= present_d;
      slot_q      <= slot_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bar_top_q    <= tfht_pkg::BAR_TOP_RST;
      bar_height_q <= tfht_pkg::BAR_HEIGHT_RST;
      bar_left_q   <= tfht_pkg::BAR_LEFT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        tfht_pkg::CFG_BAR_TOP:    bar_top_q    <= cfg_data_i;
        tfht_pkg::CFG_BAR_HEIGHT: bar_height_q <= cfg_data_i[7:0];
        tfht_pkg::CFG_BAR_LEFT:   bar_left_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    if (res_update) begin
      res_hit_q      <= res_hit_d;
      res_hit_idx_q  <= res_hit_idx_d;
      res_reg_ok_q   <= res_reg_ok_d;
      res_reg_slot_q <= res_reg_slot_d;
    end
  end

  assign slot_ext        = 8'(slot_q);
  assign result_valid_o  = res_valid_q;
  assign focus_valid_o   = present_q;
  assign focus_index_o   = present_q ? slot_ext[3:0] : 4'd0;
  assign hit_o           = res_hit_q;
  assign hit_index_o     = res_hit_idx_q;
  assign register_ok_o   = res_reg_ok_q;
  assign register_slot_o = res_reg_slot_q;

  // Checks on the sequencer and the focus state.
  `TFHT_ASSERT(a_no_result_while_scanning, !(res_valid_q && busy_o), "result strobed while busy")
  `TFHT_ASSERT(a_count_in_range, count_q <= CW'(MaxWindows), "window count beyond slot limit")
  `TFHT_ASSERT(a_focus_registered, !present_q || (CW'(slot_q) < count_q), "focus on unregistered slot")
  `TFHT_ASSERT_NEXT(a_accept_progress, accept, res_valid_q || busy_o, "accepted item left no trace")

endmodule

/* rtl/core/tfht_scan_unit.sv */
// ----------------------------------------------------------------------------
// Slot scan unit
// Walks the window slots one per cycle with a shared open test, column
// compare and index step. In click mode it lays out the open buttons and
// tests the mouse column; in cycle mode it finds the next open slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tfht_scan_unit #(
  parameter int MaxWindows = tfht_pkg::MAX_WINDOWS_DEF,
  localparam int SW = $clog2(MaxWindows),
  localparam int CW = $clog2(MaxWindows + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tfht_pkg::scan_ctrl_t   ctrl_i,
  input  logic [CW-1:0]          count_i,
  input  logic [SW-1:0]          start_idx_i,
  input  logic [15:0]            mask_i,
  input  logic [11:0]            mouse_x_i,
  input  logic [11:0]            bar_left_i,
  input  logic                   y_ok_i,
  output tfht_pkg::scan_status_t status_o,
  output logic [SW-1:0]          idx_o
);

  // Index width that can also hold the mask size.
  localparam int OW = (SW > 5) ? SW : 5;
  localparam int XW = tfht_pkg::XW;

  logic [SW-1:0] idx_q, idx_d;
  logic [CW-1:0] remain_q, remain_d;
  logic          click_q, click_d;
  logic [CW-1:0] count_q;
  logic [XW-1:0] x_q, x_d;
  logic [15:0]   mask_q;
  logic [11:0]   mx_q;
  logic          y_ok_q;

  logic [OW-1:0] idx_w;
  logic          slot_open;
  logic [XW-1:0] mx_w;
  logic [XW-1:0] x_hi;
  logic          in_x;
  logic          found;
  logic          done;
  logic [CW-1:0] last_q;
  logic [CW-1:0] last_in;
  logic [SW-1:0] idx_next;
  logic [SW-1:0] start_next;

  // Open test and column compare for the current slot.
  assign idx_w     = OW'(idx_q);
  assign slot_open = (idx_w < OW'(tfht_pkg::MASK_SLOTS)) && mask_q[idx_w[3:0]];
  assign mx_w      = XW'(mx_q);
  assign x_hi      = x_q + XW'(tfht_pkg::BTN_WIDTH);
  assign in_x      = (mx_w >= x_q) && (mx_w < x_hi);
  assign found     = (remain_q != '0) && slot_open && (!click_q || (in_x && y_ok_q));
  assign done      = (remain_q == '0) || found;

  // Round-robin index step over the registered slots.
  assign last_q     = count_q - CW'(1);
  assign idx_next   = (idx_q == last_q[SW-1:0]) ? '0 : idx_q + SW'(1);
  assign last_in    = count_i - CW'(1);
  assign start_next = (start_idx_i == last_in[SW-1:0]) ? '0 : start_idx_i + SW'(1);

  // Next state of the scan.
  always_comb begin
    idx_d    = idx_q;
    remain_d = remain_q;
    click_d  = click_q;
    x_d      = x_q;
    if (ctrl_i.load) begin
      idx_d    = ctrl_i.click_mode ? '0 : start_next;
      remain_d = count_i;
      click_d  = ctrl_i.click_mode;
      x_d      = XW'(bar_left_i);
    end else if (ctrl_i.step && !done) begin
      idx_d    = idx_next;
      remain_d = remain_q - CW'(1);
      if (click_q && slot_open) begin
        x_d = x_q + XW'(tfht_pkg::BTN_PITCH);
      end
    end
  end

  // Scan control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      remain_q <= '0;
      click_q  <= 1'b0;
    end else begin
      idx_q    <= idx_d;
      remain_q <= remain_d;
      click_q  <= click_d;
    end
  end

  // Column accumulator, and the operands captured for the whole scan.
  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    if (ctrl_i.load) begin
      count_q <= count_i;
      mask_q  <= mask_i;
      mx_q    <= mouse_x_i;
      y_ok_q  <= y_ok_i;
    end
  end

  assign status_o.done  = done;
  assign status_o.found = found;
  assign idx_o          = idx_q;

endmodule

/* test/tfht_focus_checker.sv */
// ----------------------------------------------------------------------------
// Focus result checker for the taskbar focus hit tester
// Watches the item, result and configuration channels, keeps its own copy of
// the window count, the focus and the bar registers, predicts one result per
// accepted item and compares every strobed result against the oldest one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tfht_focus_checker
  import tfht_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Item command channel
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  kind_i,
  input  logic [3:0]  window_index_i,
  input  logic [15:0] open_mask_i,
  input  logic [11:0] mouse_x_i,
  input  logic [11:0] mouse_y_i,
  // Result channel
  input  logic        result_valid_i,
  input  logic        focus_valid_i,
  input  logic [3:0]  focus_index_i,
  input  logic        hit_i,
  input  logic [3:0]  hit_index_i,
  input  logic        register_ok_i,
  input  logic [3:0]  register_slot_i,
  // Configuration channel
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i,
  // Counters for the testbench top
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);

  localparam int MaxWin = MAX_WINDOWS_DEF;
  localparam int MaxReports = 10;

  typedef struct packed {
    logic       focus_valid;
    logic [3:0] focus_index;
    logic       hit;
    logic [3:0] hit_index;
    logic       register_ok;
    logic [3:0] register_slot;
  } focus_result_t;

  // Shadow copy of the bar registers.
  logic [11:0] shadow_top;
  logic [7:0]  shadow_height;
  logic [11:0] shadow_left;

  // Predicted window and focus state.
  int win_count;
  bit has_focus;
  int focus_at;

  focus_result_t focus_results_q[$];
  focus_result_t got_result;
  focus_result_t want_result;
  int n_fail;
  int n_checked;

  // Works out the result of one item and advances the predicted state.
  function automatic focus_result_t compute_focus_result(
    input logic [1:0]  kind,
    input logic [3:0]  widx,
    input logic [15:0] mask,
    input logic [11:0] mx,
    input logic [11:0] my
  );
    focus_result_t res;
    int btn_h;
    int btn_y;
    int col;
    int mxi;
    int myi;
    int start;
    int idx;
    int i;
    bit found;
    res = '0;
    found = 1'b0;
    mxi = mx;
    myi = my;
    case (kind)
      KIND_REGISTER: begin
        if (win_count < MaxWin) begin
          res.register_ok = 1'b1;
          res.register_slot = 4'(win_count);
          if (!has_focus) begin
            has_focus = 1'b1;
            focus_at = win_count;
          end
          win_count = win_count + 1;
        end
      end
      KIND_SET_FOCUS: begin
        if (int'(widx) < win_count) begin
          has_focus = 1'b1;
          focus_at = widx;
        end
      end
      KIND_CLICK: begin
        btn_h = int'(shadow_height) - BTN_SHRINK;
        btn_y = int'(shadow_top) + BTN_SHRINK / 2;
        col = int'(shadow_left);
        // Open windows are laid out left to right in slot order.
        for (i = 0; i < win_count; i++) begin
          if (!found && i < MASK_SLOTS && mask[i]) begin
            if (mxi >= col && mxi < col + BTN_WIDTH &&
                myi >= btn_y && myi < btn_y + btn_h) begin
              found = 1'b1;
              has_focus = 1'b1;
              focus_at = i;
              res.hit = 1'b1;
              res.hit_index = 4'(i);
            end
            col = col + BTN_PITCH;
          end
        end
      end
      default: begin
        // Round robin from the slot after the focused one.
        if (win_count != 0) begin
          start = (has_focus && focus_at < win_count) ? focus_at : 0;
          for (i = 1; i <= win_count; i++) begin
            idx = (start + i) % win_count;
            if (!found && idx < MASK_SLOTS && mask[idx]) begin
              found = 1'b1;
              has_focus = 1'b1;
              focus_at = idx;
            end
          end
        end
      end
    endcase
    res.focus_valid = has_focus;
    res.focus_index = has_focus ? 4'(focus_at) : 4'd0;
    return res;
  endfunction

  // Compare results, track configuration writes and queue predictions.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_top = BAR_TOP_RST;
      shadow_height = BAR_HEIGHT_RST;
      shadow_left = BAR_LEFT_RST;
      win_count = 0;
      has_focus = 1'b0;
      focus_at = 0;
      focus_results_q.delete();
    end else begin
      // A result leaves no earlier than the cycle after its item, so compare first.
      if (result_valid_i) begin
        got_result = {focus_valid_i, focus_index_i, hit_i, hit_index_i,
                      register_ok_i, register_slot_i};
        if (focus_results_q.size() == 0) begin
          n_fail++;
          if (n_fail <= MaxReports) begin
            $display("[%0t] result with no item waiting: fv=%0d fi=%0d hit=%0d hi=%0d ok=%0d slot=%0d",
                     $realtime, got_result.focus_valid, got_result.focus_index,
                     got_result.hit, got_result.hit_index, got_result.register_ok,
                     got_result.register_slot);
          end
        end else begin
          want_result = focus_results_q.pop_front();
          n_checked++;
          if (got_result !== want_result) begin
            n_fail++;
            if (n_fail <= MaxReports) begin
              $display("[%0t] mismatch: expected fv=%0d fi=%0d hit=%0d hi=%0d ok=%0d slot=%0d",
                       $realtime, want_result.focus_valid, want_result.focus_index,
                       want_result.hit, want_result.hit_index, want_result.register_ok,
                       want_result.register_slot);
              $display("             actual   fv=%0d fi=%0d hit=%0d hi=%0d ok=%0d slot=%0d",
                       got_result.focus_valid, got_result.focus_index,
                       got_result.hit, got_result.hit_index, got_result.register_ok,
                       got_result.register_slot);
            end
          end
        end
      end
      // Register write transfer.
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_BAR_TOP: shadow_top = cfg_data_i;
          CFG_BAR_HEIGHT: shadow_height = cfg_data_i[7:0];
          CFG_BAR_LEFT: shadow_left = cfg_data_i;
          default: ;
        endcase
      end
      // Item transfer.
      if (start_i && !busy_i) begin
        focus_results_q.push_back(compute_focus_result(kind_i, window_index_i,
                                                       open_mask_i, mouse_x_i, mouse_y_i));
      end
    end
    fail_count_o <= n_fail;
    pending_o <= focus_results_q.size();
    checked_o <= n_checked;
  end

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// Testbench for the taskbar focus hit tester
// Drives a directed opening and random items over a series of bar settings,
// with random gaps between items, and leaves prediction and comparison to the
// focus result checker. Reports the verdict at the end of the run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import tfht_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int NumSettings = 9;
  localparam int ItemsPerSetting = 122;
  localparam int MaxGap = 17;
  localparam int DrainCycles = 24;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  kind_i = KIND_REGISTER;
  logic [3:0]  window_index_i = '0;
  logic [15:0] open_mask_i = '0;
  logic [11:0] mouse_x_i = '0;
  logic [11:0] mouse_y_i = '0;
  logic        result_valid_o;
  logic        focus_valid_o;
  logic [3:0]  focus_index_o;
  logic        hit_o;
  logic [3:0]  hit_index_o;
  logic        register_ok_o;
  logic [3:0]  register_slot_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = CFG_BAR_TOP;
  logic [11:0] cfg_data_i = '0;

  int fail_count;
  int pending;
  int checked;
  int cycle_count = 0;

  // Stimulus side view of the block.
  int n_registered = 0;
  int n_items = 0;
  int cur_top = BAR_TOP_RST;
  int cur_height = BAR_HEIGHT_RST;
  int cur_left = BAR_LEFT_RST;
  bit burst = 1'b0;

  taskbar_focus_hit_tester_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .kind_i          (kind_i),
    .window_index_i  (window_index_i),
    .open_mask_i     (open_mask_i),
    .mouse_x_i       (mouse_x_i),
    .mouse_y_i       (mouse_y_i),
    .result_valid_o  (result_valid_o),
    .focus_valid_o   (focus_valid_o),
    .focus_index_o   (focus_index_o),
    .hit_o           (hit_o),
    .hit_index_o     (hit_index_o),
    .register_ok_o   (register_ok_o),
    .register_slot_o (register_slot_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  tfht_focus_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_i          (busy_o),
    .kind_i          (kind_i),
    .window_index_i  (window_index_i),
    .open_mask_i     (open_mask_i),
    .mouse_x_i       (mouse_x_i),
    .mouse_y_i       (mouse_y_i),
    .result_valid_i  (result_valid_o),
    .focus_valid_i   (focus_valid_o),
    .focus_index_i   (focus_index_o),
    .hit_i           (hit_o),
    .hit_index_i     (hit_index_o),
    .register_ok_i   (register_ok_o),
    .register_slot_i (register_slot_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .checked_o       (checked)
  );

  // 20 ns clock.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Watchdog on the cycle count.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results still waiting", cycle_count, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Presents one item after a random gap (none in a burst) and holds it until its transfer.
  task automatic send_item(input logic [1:0] kind, input logic [3:0] widx,
                           input logic [15:0] mask, input logic [11:0] mx,
                           input logic [11:0] my);
    int gap;
    gap = burst ? 0 : $urandom_range(0, MaxGap);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    kind_i <= kind;
    window_index_i <= widx;
    open_mask_i <= mask;
    mouse_x_i <= mx;
    mouse_y_i <= my;
    do @(posedge clk_i); while (busy_o);
    n_items++;
    if (kind == KIND_REGISTER && n_registered < MAX_WINDOWS_DEF) n_registered++;
  endtask

  // Lets every outstanding result arrive, then lets the block drain.
  task automatic wait_idle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy_o) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [11:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Reprograms the bar once the block has gone quiet.
  task automatic set_bar(input int top, input int height, input int left);
    wait_idle();
    cur_top = top;
    cur_height = height;
    cur_left = left;
    write_cfg(CFG_BAR_TOP, 12'(top));
    // Only the low byte counts for the height; the upper bits are noise.
    write_cfg(CFG_BAR_HEIGHT, {4'($urandom), 8'(height)});
    write_cfg(CFG_BAR_LEFT, 12'(left));
  endtask

  // Left column of a slot's button for a given open mask.
  function automatic int button_column(input int slot, input logic [15:0] mask);
    int pos;
    int i;
    pos = 0;
    for (i = 0; i < slot; i++) begin
      if (mask[i]) pos++;
    end
    return cur_left + pos * BTN_PITCH;
  endfunction

  function automatic logic [15:0] pick_mask();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h0001 << $urandom_range(0, 15);
      default: return 16'($urandom);
    endcase
  endfunction

  // One random item; most clicks are aimed at or just beside a button.
  task automatic random_item();
    int r;
    int slot;
    int col;
    int row;
    logic [15:0] mask;
    logic [3:0]  widx;
    logic [11:0] mx;
    logic [11:0] my;
    r = $urandom_range(0, 99);
    mask = pick_mask();
    widx = 4'($urandom);
    mx = 12'($urandom);
    my = 12'($urandom);
    if (r < 6) begin
      send_item(KIND_REGISTER, widx, mask, mx, my);
    end else if (r < 26) begin
      if ($urandom_range(0, 3) != 0 && n_registered > 0)
        widx = 4'($urandom_range(0, n_registered - 1));
      send_item(KIND_SET_FOCUS, widx, mask, mx, my);
    end else if (r < 70) begin
      if ($urandom_range(0, 3) != 0 && n_registered > 0) begin
        slot = $urandom_range(0, n_registered - 1);
        mask[slot] = 1'b1;
        col = button_column(slot, mask);
        case ($urandom_range(0, 5))
          0: col = col;
          1: col = col + BTN_WIDTH - 1;
          2: col = col + BTN_WIDTH + $urandom_range(0, BTN_PITCH - BTN_WIDTH - 1);
          3: col = col - 1;
          default: col = col + $urandom_range(0, BTN_WIDTH - 1);
        endcase
        case ($urandom_range(0, 5))
          0: row = cur_top + 2;
          1: row = cur_top + cur_height - 3;
          2: row = cur_top + 1;
          3: row = cur_top + cur_height - 2;
          default: row = cur_top + 2 + $urandom_range(0, (cur_height > 5) ? cur_height - 5 : 0);
        endcase
        mx = 12'(col);
        my = 12'(row);
      end
      send_item(KIND_CLICK, widx, mask, mx, my);
    end else begin
      send_item(KIND_CYCLE, widx, mask, mx, my);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening at the reset bar geometry.
    set_bar(BAR_TOP_RST, BAR_HEIGHT_RST, BAR_LEFT_RST);
    write_cfg(CFG_UNUSED, 12'($urandom));
    burst = 1'b1;
    // Nothing registered yet.
    send_item(KIND_CYCLE, 4'h0, 16'hFFFF, 12'd0, 12'd0);
    send_item(KIND_SET_FOCUS, 4'h0, 16'hFFFF, 12'd0, 12'd0);
    send_item(KIND_CLICK, 4'h0, 16'hFFFF, 12'd10, 12'd10);
    // The first window takes focus, later ones do not.
    send_item(KIND_REGISTER, 4'hF, 16'h0000, 12'hFFF, 12'hFFF);
    send_item(KIND_REGISTER, 4'h0, 16'hFFFF, 12'd0, 12'd0);
    burst = 1'b0;
    send_item(KIND_REGISTER, 4'h5, 16'h1234, 12'd77, 12'd3);
    // Clicks on, between, above and below the buttons.
    send_item(KIND_CLICK, 4'h0, 16'h0007, 12'(button_column(1, 16'h0007) + 5), 12'd2);
    send_item(KIND_CLICK, 4'h0, 16'h0007, 12'(BTN_WIDTH + 1), 12'd10);
    send_item(KIND_CLICK, 4'h0, 16'h0007, 12'd0, 12'd1);
    send_item(KIND_CLICK, 4'h0, 16'h0007, 12'(BTN_WIDTH - 1), 12'(cur_height - 3));
    send_item(KIND_CLICK, 4'h0, 16'h0007, 12'd5, 12'(cur_height - 2));
    // A closed slot shifts the later buttons to the left.
    send_item(KIND_CLICK, 4'h0, 16'h0006, 12'd0, 12'd15);
    send_item(KIND_CLICK, 4'h0, 16'h0007, 12'(button_column(3, 16'h0007) + 1), 12'd15);
    // Set focus in and out of range.
    send_item(KIND_SET_FOCUS, 4'h2, 16'h0000, 12'd0, 12'd0);
    send_item(KIND_SET_FOCUS, 4'h3, 16'hFFFF, 12'd0, 12'd0);
    send_item(KIND_SET_FOCUS, 4'hF, 16'hFFFF, 12'hFFF, 12'hFFF);
    // Cycling with no open window, with wrap-around and with a far mask bit.
    send_item(KIND_CYCLE, 4'h0, 16'h0000, 12'd0, 12'd0);
    send_item(KIND_CYCLE, 4'h0, 16'h0001, 12'd0, 12'd0);
    send_item(KIND_CYCLE, 4'h0, 16'hFFFF, 12'd0, 12'd0);
    send_item(KIND_CYCLE, 4'hF, 16'h8000, 12'd0, 12'd0);
    send_item(KIND_CLICK, 4'hF, 16'hFFFF, 12'hFFF, 12'hFFF);

    // Random items over a series of bar settings.
    for (int setting = 0; setting < NumSettings; setting++) begin
      case (setting)
        0: set_bar(BAR_TOP_RST, BAR_HEIGHT_RST, BAR_LEFT_RST);
        1: set_bar(0, 5, 0);
        2: set_bar(4095, 255, 4095);
        3: set_bar(100, 4, 50);
        4: set_bar($urandom_range(0, 3000), $urandom_range(5, 255), $urandom_range(0, 2000));
        5: set_bar(2000, 0, 1000);
        6: set_bar(3900, 255, 2100);
        7: set_bar(0, 255, 0);
        default: set_bar($urandom_range(0, 4095), $urandom_range(5, 255),
                         $urandom_range(0, 4095));
      endcase
      repeat (ItemsPerSetting) begin
        if ($urandom_range(0, 39) == 0) burst = !burst;
        random_item();
      end
    end

    wait_idle();
    $display("Covered %0d items over %0d bar settings plus the reset one; %0d results compared.",
             n_items, NumSettings, checked);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d failures", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/tfht_pkg.sv
rtl/core/tfht_scan_unit.sv
rtl/core/taskbar_focus_hit_tester_unit.sv
test/tfht_focus_checker.sv
test/tb_top.sv
